FILE: hw/rtl/quaternion_to_euler_angles_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle converter
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH

// Same-cycle implication.
`define QTE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qte assertion failed");

// Next-cycle implication.
`define QTE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qte assertion failed");

`endif

FILE: hw/rtl/qte_pkg.sv
// ---------------------------------------------------------------------------
// qte_pkg
// Shared constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package qte_pkg;

    // Angle accumulator width, Q.30 with headroom past pi plus the table sum.
    localparam int ANG_W    = 35;
    localparam int ATAN_LEN = 24;

    localparam logic signed [ANG_W-1:0] PI_Q30     = 35'sd3373259426;
    // Half pi in Q3.13 moved up to Q.30, so it rounds back to exactly 12868.
    localparam logic signed [ANG_W-1:0] GIMBAL_Q30 = 35'sd1686634496;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

    // Rounded atan(2^-i) in Q.30.
    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            0:       a = 35'sd843314857;
            1:       a = 35'sd497837830;
            2:       a = 35'sd263043837;
            3:       a = 35'sd133525159;
            4:       a = 35'sd67021687;
            5:       a = 35'sd33543516;
            6:       a = 35'sd16775851;
            7:       a = 35'sd8388437;
            8:       a = 35'sd4194283;
            9:       a = 35'sd2097149;
            10:      a = 35'sd1048576;
            11:      a = 35'sd524288;
            12:      a = 35'sd262144;
            13:      a = 35'sd131072;
            14:      a = 35'sd65536;
            15:      a = 35'sd32768;
            16:      a = 35'sd16384;
            17:      a = 35'sd8192;
            18:      a = 35'sd4096;
            19:      a = 35'sd2048;
            20:      a = 35'sd1024;
            21:      a = 35'sd512;
            22:      a = 35'sd256;
            23:      a = 35'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: hw/rtl/qte_sqrt_cell.sv
// ---------------------------------------------------------------------------
// qte_sqrt_cell
// One restoring square root step: brings in two radicand bits and decides
// one root bit. Carries a side bus along so the other channels stay aligned.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qte_sqrt_cell #(
    parameter int RAD_W  = 30,
    parameter int ROOT_W = 15,
    parameter int REM_W  = 18,
    parameter int PASS_W = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [PASS_W-1:0] i_pass,
    output logic [RAD_W-1:0]  o_rad,
    output logic [REM_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root,
    output logic [PASS_W-1:0] o_pass
);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [PASS_W-1:0] r_pass;

    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W-1:0]  w_trial;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;

    // Trial subtract of 4*root + 1 from the shifted remainder.
    always_comb begin
        w_rem_sh = {i_rem[REM_W-3:0], i_rad[RAD_W-1:RAD_W-2]};
        w_trial  = REM_W'({i_root, 2'b01});
        if (w_rem_sh >= w_trial) begin
            n_rem  = w_rem_sh - w_trial;
            n_root = {i_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = w_rem_sh;
            n_root = {i_root[ROOT_W-2:0], 1'b0};
        end
    end

    // Step register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pass <= i_pass;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pass = r_pass;

endmodule

FILE: hw/rtl/qte_cordic_cell.sv
// ---------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation on a packed {x, y, angle, hold} vector.
// A held vector passes through unchanged.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int CW    = 19,
    parameter int SHIFT = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [2*CW+ANG_W:0]       i_vec,
    output logic [2*CW+ANG_W:0]       o_vec
);

    localparam int VEC_W = 2 * CW + ANG_W + 1;
    localparam logic signed [ANG_W-1:0] ATAN_STEP = atan_q30(SHIFT);

    logic signed [CW-1:0]    w_x, w_y, w_dx, w_dy, n_x, n_y;
    logic signed [ANG_W-1:0] w_ang, n_ang;
    logic                    w_hold;
    logic [VEC_W-1:0]        r_vec;

    // Unpack and rotate toward the x axis.
    always_comb begin
        w_x    = $signed(i_vec[VEC_W-1 -: CW]);
        w_y    = $signed(i_vec[VEC_W-1-CW -: CW]);
        w_ang  = $signed(i_vec[ANG_W:1]);
        w_hold = i_vec[0];
        w_dx   = w_y >>> SHIFT;
        w_dy   = w_x >>> SHIFT;
        if (w_hold) begin
            n_x   = w_x;
            n_y   = w_y;
            n_ang = w_ang;
        end else if (!w_y[CW-1]) begin
            n_x   = w_x + w_dx;
            n_y   = w_y - w_dy;
            n_ang = w_ang + ATAN_STEP;
        end else begin
            n_x   = w_x - w_dx;
            n_y   = w_y + w_dy;
            n_ang = w_ang - ATAN_STEP;
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= {n_x, n_y, n_ang, w_hold};
        end
    end

    assign o_vec = r_vec;

endmodule

FILE: hw/rtl/qte_front.sv
// ---------------------------------------------------------------------------
// qte_front
// Front end: quaternion products, rotation matrix terms, rounding into the
// working format, atan2 quadrant setup and the pitch cosine radicand.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qte_front
    import qte_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [15:0]                i_w,
    input  logic signed [15:0]                i_x,
    input  logic signed [15:0]                i_y,
    input  logic signed [15:0]                i_z,
    output logic [2*(FRAC_BITS+5)+ANG_W:0]    o_roll_vec,
    output logic [2*(FRAC_BITS+5)+ANG_W:0]    o_yaw_vec,
    output logic [2*(FRAC_BITS+5)+ANG_W:0]    o_pitch_vec,
    output logic [2*FRAC_BITS+1:0]            o_radicand
);

    localparam int WW    = FRAC_BITS + 3;
    localparam int CW    = FRAC_BITS + 5;
    localparam int VEC_W = 2 * CW + ANG_W + 1;
    localparam int MAG_W = FRAC_BITS + 1;
    localparam int RAD_W = 2 * FRAC_BITS + 2;
    localparam int SW    = 40;
    localparam int DN    = (FRAC_BITS < 28) ? 28 - FRAC_BITS : 0;
    localparam int UP    = (FRAC_BITS > 28) ? FRAC_BITS - 28 : 0;
    localparam logic signed [SW-1:0] RND   = (40'sd1 <<< DN) >>> 1;
    localparam logic signed [SW-1:0] LIM   = 40'sd1 <<< (FRAC_BITS + 2);
    localparam logic signed [SW-1:0] ONE28 = 40'sd1 <<< 28;
    localparam logic signed [WW-1:0] ONE_W = WW'(40'sd1 <<< FRAC_BITS);
    localparam logic [RAD_W-1:0]     ONE_SQ = RAD_W'(1) << (2 * FRAC_BITS);

    // Q.28 to working format, round half up, saturate to [-4, 4).
    function automatic logic signed [SW-1:0] to_work(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = ((v + RND) >>> DN) <<< UP;
        if (r > LIM - 40'sd1) begin
            r = LIM - 40'sd1;
        end else if (r < -LIM) begin
            r = -LIM;
        end
        return r;
    endfunction

    // Zero vector holds at angle 0; a left half-plane vector turns by pi.
    function automatic logic [VEC_W-1:0] prerot(input logic signed [WW-1:0] y,
                                                input logic signed [WW-1:0] x);
        logic signed [CW-1:0]    xe, ye;
        logic signed [ANG_W-1:0] ang;
        logic                    hold;
        xe   = CW'(x);
        ye   = CW'(y);
        ang  = '0;
        hold = 1'b0;
        if (x == '0 && y == '0) begin
            hold = 1'b1;
        end else if (x[WW-1]) begin
            ang = y[WW-1] ? -PI_Q30 : PI_Q30;
            xe  = -xe;
            ye  = -ye;
        end
        return {xe, ye, ang, hold};
    endfunction

    logic signed [31:0] r_p_wx, r_p_yz, r_p_xx, r_p_yy, r_p_wz;
    logic signed [31:0] r_p_xy, r_p_zz, r_p_wy, r_p_zx;
    logic signed [SW-1:0] r_ry28, r_rx28, r_yy28, r_yx28, r_s28;
    logic signed [SW-1:0] w_s28;
    logic signed [WW-1:0] r_wk_ry, r_wk_rx, r_wk_yy, r_wk_yx, r_wk_s;
    logic [VEC_W-1:0]     r_roll4, r_yaw4, r_pitch4;
    logic [RAD_W-1:0]     r_mag_sq;
    logic [VEC_W-1:0]     r_roll5, r_yaw5, r_pitch5;
    logic [RAD_W-1:0]     r_rad5;
    logic [MAG_W-1:0]     w_mag;
    logic [RAD_W-1:0]     w_mag_ext;
    logic signed [ANG_W-1:0] w_p_ang;
    logic                 w_p_hold;

    // Stage 1: component products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_wx <= i_w * i_x;
            r_p_yz <= i_y * i_z;
            r_p_xx <= i_x * i_x;
            r_p_yy <= i_y * i_y;
            r_p_wz <= i_w * i_z;
            r_p_xy <= i_x * i_y;
            r_p_zz <= i_z * i_z;
            r_p_wy <= i_w * i_y;
            r_p_zx <= i_z * i_x;
        end
    end

    // Pitch sine term, clamped to plus or minus one.
    always_comb begin
        w_s28 = (SW'(r_p_wy) - SW'(r_p_zx)) <<< 1;
        if (w_s28 > ONE28) begin
            w_s28 = ONE28;
        end else if (w_s28 < -ONE28) begin
            w_s28 = -ONE28;
        end
    end

    // Stage 2: exact Q.28 matrix terms.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ry28 <= (SW'(r_p_wx) + SW'(r_p_yz)) <<< 1;
            r_rx28 <= ONE28 - ((SW'(r_p_xx) + SW'(r_p_yy)) <<< 1);
            r_yy28 <= (SW'(r_p_wz) + SW'(r_p_xy)) <<< 1;
            r_yx28 <= ONE28 - ((SW'(r_p_yy) + SW'(r_p_zz)) <<< 1);
            r_s28  <= w_s28;
        end
    end

    // Stage 3: working format.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wk_ry <= WW'(to_work(r_ry28));
            r_wk_rx <= WW'(to_work(r_rx28));
            r_wk_yy <= WW'(to_work(r_yy28));
            r_wk_yx <= WW'(to_work(r_yx28));
            r_wk_s  <= WW'(to_work(r_s28));
        end
    end

    // Pitch magnitude and gimbal lock detection.
    always_comb begin
        w_mag     = MAG_W'(r_wk_s[WW-1] ? -r_wk_s : r_wk_s);
        w_mag_ext = RAD_W'(w_mag);
        w_p_hold  = 1'b0;
        w_p_ang   = '0;
        if (r_wk_s >= ONE_W) begin
            w_p_hold = 1'b1;
            w_p_ang  = GIMBAL_Q30;
        end else if (r_wk_s <= -ONE_W) begin
            w_p_hold = 1'b1;
            w_p_ang  = -GIMBAL_Q30;
        end
    end

    // Stage 4: quadrant setup and the squared sine.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_roll4  <= prerot(r_wk_ry, r_wk_rx);
            r_yaw4   <= prerot(r_wk_yy, r_wk_yx);
            r_pitch4 <= {CW'(0), CW'(r_wk_s), w_p_ang, w_p_hold};
            r_mag_sq <= w_mag_ext * w_mag_ext;
        end
    end

    // Stage 5: cosine squared as the square root radicand.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_roll5  <= r_roll4;
            r_yaw5   <= r_yaw4;
            r_pitch5 <= r_pitch4;
            r_rad5   <= ONE_SQ - r_mag_sq;
        end
    end

    assign o_roll_vec  = r_roll5;
    assign o_yaw_vec   = r_yaw5;
    assign o_pitch_vec = r_pitch5;
    assign o_radicand  = r_rad5;

endmodule

FILE: hw/rtl/quaternion_to_euler_angles_top.sv
// ---------------------------------------------------------------------------
// Quaternion to Euler angle converter
// ZYX roll, pitch and yaw from a Q1.14 quaternion through a pipelined front
// end, a chain of square root cells and three chains of CORDIC cells.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_ready   i_quat_w, i_quat_x, i_quat_y, i_quat_z
//  result   out        o_valid / i_ready   o_roll_angle, o_pitch_angle, o_yaw_angle
//
// One quaternion is taken per cycle unless the output stalls. The path runs
// through five front stages, one square root cell per root bit, one CORDIC
// cell per step (STEPS, CORDIC_STEPS capped at 24) and the output register.
// A result waiting in the output register that is not taken freezes the
// whole pipeline in place; nothing is dropped. Reset clears only valid bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_top_assert.svh"

module quaternion_to_euler_angles_top
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle
);

    localparam int CW     = FRAC_BITS + 5;
    localparam int VEC_W  = 2 * CW + ANG_W + 1;
    localparam int ROOT_W = FRAC_BITS + 1;
    localparam int RAD_W  = 2 * FRAC_BITS + 2;
    localparam int REM_W  = FRAC_BITS + 4;
    localparam int PASS_W = 3 * VEC_W;
    localparam int STEPS  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int LAT    = 5 + ROOT_W + STEPS;

    // Q.30 angle to Q3.13, round by adding half and flooring, then clamp.
    function automatic logic signed [17:0] to_q13(input logic signed [ANG_W-1:0] a,
                                                  input logic signed [17:0] lim);
        logic signed [ANG_W-1:0] t;
        logic signed [ANG_W-1:0] l;
        t = (a + 35'sd65536) >>> 17;
        l = ANG_W'(lim);
        if (t > l) begin
            t = l;
        end else if (t < -l) begin
            t = -l;
        end
        return 18'(t);
    endfunction

    logic             w_en;
    logic [LAT-1:0]   r_valid;
    logic             r_out_valid;
    logic signed [15:0] r_roll, r_yaw;
    logic signed [14:0] r_pitch;

    logic [VEC_W-1:0] w_roll0, w_yaw0, w_pitch0;
    logic [RAD_W-1:0] w_rad0;

    logic [RAD_W-1:0]  sq_rad  [ROOT_W+1];
    logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root [ROOT_W+1];
    logic [PASS_W-1:0] sq_pass [ROOT_W+1];

    logic [VEC_W-1:0]  cv [3][STEPS+1];
    logic [VEC_W-1:0]  w_pitch_sq;

    // The pipeline moves whenever the output register is free or drained.
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    qte_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_w         (i_quat_w),
        .i_x         (i_quat_x),
        .i_y         (i_quat_y),
        .i_z         (i_quat_z),
        .o_roll_vec  (w_roll0),
        .o_yaw_vec   (w_yaw0),
        .o_pitch_vec (w_pitch0),
        .o_radicand  (w_rad0)
    );

    // Square root chain for the pitch cosine; the vectors ride along.
    assign sq_rad[0]  = w_rad0;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_pass[0] = {w_roll0, w_yaw0, w_pitch0};

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        qte_sqrt_cell #(
            .RAD_W  (RAD_W),
            .ROOT_W (ROOT_W),
            .REM_W  (REM_W),
            .PASS_W (PASS_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (sq_rad[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_pass (sq_pass[g]),
            .o_rad  (sq_rad[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_pass (sq_pass[g+1])
        );
    end

    // Pitch vector: x is the cosine from the root, y is the sine.
    assign w_pitch_sq = {CW'(sq_root[ROOT_W]), sq_pass[ROOT_W][VEC_W-CW-1:0]};

    assign cv[0][0] = sq_pass[ROOT_W][PASS_W-1 -: VEC_W];
    assign cv[1][0] = sq_pass[ROOT_W][2*VEC_W-1 -: VEC_W];
    assign cv[2][0] = w_pitch_sq;

    // Three CORDIC chains: roll, yaw and pitch.
    for (genvar c = 0; c < 3; c++) begin : g_chan
        for (genvar s = 0; s < STEPS; s++) begin : g_step
            qte_cordic_cell #(
                .CW    (CW),
                .SHIFT (s)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_vec (cv[c][s]),
                .o_vec (cv[c][s+1])
            );
        end
    end

    // Valid bits track the items through the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_valid     <= {r_valid[LAT-2:0], i_valid};
            r_out_valid <= r_valid[LAT-1];
        end
    end

    // Output register with the final rounding to Q3.13.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll  <= 16'(to_q13($signed(cv[0][STEPS][ANG_W:1]), PI_Q13));
            r_yaw   <= 16'(to_q13($signed(cv[1][STEPS][ANG_W:1]), PI_Q13));
            r_pitch <= 15'(to_q13($signed(cv[2][STEPS][ANG_W:1]), HALF_PI_Q13));
        end
    end

    assign o_valid       = r_out_valid;
    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;
    assign o_yaw_angle   = r_yaw;

    // Checks on the pipeline control and the angle limits.
    `QTE_ASSERT_NXT(a_accept_enters, i_valid && o_ready, r_valid[0])
    `QTE_ASSERT_NXT(a_stall_holds, o_valid && !i_ready, $stable(r_valid))
    `QTE_ASSERT_IMP(a_pitch_range, o_valid, o_pitch_angle <= 15'sd12868 && o_pitch_angle >= -15'sd12868)
    `QTE_ASSERT_IMP(a_roll_range, o_valid, o_roll_angle <= 16'sd25736 && o_roll_angle >= -16'sd25736)
    `QTE_ASSERT_IMP(a_yaw_range, o_valid, o_yaw_angle <= 16'sd25736 && o_yaw_angle >= -16'sd25736)

endmodule

FILE: tb/tb_quaternion_to_euler_angles_top.sv
// ---------------------------------------------------------------------------
// Quaternion to Euler angle converter testbench
// Feeds directed and random quaternions through the valid/ready channels,
// predicts roll, pitch and yaw with a bit-accurate CORDIC model and checks
// every result transfer in order. Both sides idle in random bursts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles_top;
    import qte_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 14;
    localparam int STEPS        = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int LATENCY      = FRAC_BITS + STEPS + 7;
    localparam int N_RANDOM     = 1930;
    localparam int CALM_TAIL    = 200;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } t_angles;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        bit                 typed;
        t_angles            ang;
    } t_quat_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_roll_angle;
    logic signed [14:0] o_pitch_angle;
    logic signed [15:0] o_yaw_angle;

    t_angles    pending_angles[$];
    t_quat_row  directed_rows[$];
    int         mismatch_count;
    bit         calm;
    longint     cycle_count;

    quaternion_to_euler_angles_top #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_quat_w     (i_quat_w),
        .i_quat_x     (i_quat_x),
        .i_quat_y     (i_quat_y),
        .i_quat_z     (i_quat_z),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_roll_angle (o_roll_angle),
        .o_pitch_angle(o_pitch_angle),
        .o_yaw_angle  (o_yaw_angle)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Floor shift of a signed value.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Move a Q.28 term into the working format with rounding and saturation.
    function automatic longint q28_to_work(longint v);
        longint lim;
        longint r;
        lim = longint'(4) << FRAC_BITS;
        if (FRAC_BITS >= 28) begin
            r = v << (FRAC_BITS - 28);
        end else begin
            r = floor_shift(v + (longint'(1) << (27 - FRAC_BITS)), 28 - FRAC_BITS);
        end
        return clip(r, -lim, lim - 1);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC arctangent over all four quadrants, angle in Q.30.
    function automatic longint vector_angle(longint vy, longint vx);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0) begin
            acc = (vy >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shift(vy, i);
            dy = floor_shift(vx, i);
            if (vy >= 0) begin
                vx += dx; vy -= dy; acc += longint'(atan_q30(i));
            end else begin
                vx -= dx; vy += dy; acc -= longint'(atan_q30(i));
            end
        end
        return acc;
    endfunction

    function automatic longint to_q13(longint a30, longint lim);
        return clip(floor_shift(a30 + 65536, 17), -lim, lim);
    endfunction

    // Expected roll, pitch and yaw for one quaternion.
    function automatic t_angles euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                         logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, one28, one, s, mag, c;
        t_angles a;
        w = qw; x = qx; y = qy; z = qz;
        one28 = longint'(1) << 28;
        one   = longint'(1) << FRAC_BITS;
        a.roll = 16'(to_q13(vector_angle(q28_to_work(2 * (w * x + y * z)),
                      q28_to_work(one28 - 2 * (x * x + y * y))), PI_Q13));
        a.yaw  = 16'(to_q13(vector_angle(q28_to_work(2 * (w * z + x * y)),
                      q28_to_work(one28 - 2 * (y * y + z * z))), PI_Q13));
        s = q28_to_work(clip(2 * (w * y - z * x), -one28, one28));
        if (s >= one) begin
            a.pitch = 15'(HALF_PI_Q13);
        end else if (s <= -one) begin
            a.pitch = 15'(-HALF_PI_Q13);
        end else begin
            mag = (s < 0) ? -s : s;
            c = int_sqrt((longint'(1) << (2 * FRAC_BITS)) - mag * mag);
            a.pitch = 15'(to_q13(vector_angle(s, c), HALF_PI_Q13));
        end
        return a;
    endfunction

    function automatic t_quat_row row(int w, int x, int y, int z, bit typed = 0,
                                      int r = 0, int p = 0, int yw = 0);
        t_quat_row t;
        t.w = 16'(w); t.x = 16'(x); t.y = 16'(y); t.z = 16'(z);
        t.typed = typed;
        t.ang.roll = 16'(r); t.ang.pitch = 15'(p); t.ang.yaw = 16'(yw);
        return t;
    endfunction

    // Append one row to the directed table.
    task automatic add_row(t_quat_row t);
        directed_rows = {directed_rows, t};
    endtask

    // Append one prediction to the scoreboard.
    task automatic queue_expected(t_angles a);
        pending_angles = {pending_angles, a};
    endtask

    // Random burst of idle cycles on the sending side.
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one quaternion and hold it until the transfer.
    task automatic send_quat(t_quat_row t);
        i_valid  <= 1'b1;
        i_quat_w <= t.w;
        i_quat_x <= t.x;
        i_quat_y <= t.y;
        i_quat_z <= t.z;
        queue_expected(t.typed ? t.ang : euler_of(t.w, t.x, t.y, t.z));
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_and_drop(t_quat_row t);
        send_quat(t);
        sender_gap();
    endtask

    // Pick a component, mostly in range, sometimes any pattern.
    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Roughly unit quaternion with random direction.
    function automatic t_quat_row rand_unit();
        real a, b, c, d, n;
        a = $itor($signed($urandom_range(0, 2000)) - 1000);
        b = $itor($signed($urandom_range(0, 2000)) - 1000);
        c = $itor($signed($urandom_range(0, 2000)) - 1000);
        d = $itor($signed($urandom_range(0, 2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) return row(16384, 0, 0, 0);
        return row($rtoi(a / n * 16383.0), $rtoi(b / n * 16383.0),
                   $rtoi(c / n * 16383.0), $rtoi(d / n * 16383.0));
    endfunction

    // Receiver stalls in random bursts.
    initial begin
        int n;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge i_clk);
        end
    end

    // Result checker: every transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_angles.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result roll=%0d pitch=%0d yaw=%0d",
                             o_roll_angle, o_pitch_angle, o_yaw_angle);
            end else begin
                want = pending_angles.pop_front();
                if (want.roll !== o_roll_angle || want.pitch !== o_pitch_angle ||
                    want.yaw !== o_yaw_angle) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected roll=%0d pitch=%0d yaw=%0d, %s%0d %0d %0d",
                                 want.roll, want.pitch, want.yaw, "got ",
                                 o_roll_angle, o_pitch_angle, o_yaw_angle);
                end
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_quat_row t;
        mismatch_count = 0;
        cycle_count    = 0;
        calm           = 1'b0;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_quat_w = '0; i_quat_x = '0; i_quat_y = '0; i_quat_z = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: identity, gimbal lock, zero vector, saturation.
        // The doubled gimbal rows also flip roll and yaw to plus pi.
        add_row(row(16384, 0, 0, 0, 1, 0, 0, 0));
        add_row(row(0, 0, 0, 0, 1, 0, 0, 0));
        add_row(row(11585, 0, 11585, 0));
        add_row(row(11585, 0, -11585, 0));
        add_row(row(16384, 0, 16384, 0, 1, 25736, 12868, 25736));
        add_row(row(16384, 0, -16384, 0, 1, 25736, -12868, 25736));
        add_row(row(0, 16384, 0, 0));
        add_row(row(0, 0, 0, 16384));
        add_row(row(0, 0, 16384, 0));
        add_row(row(0, -16384, 0, 0));
        add_row(row(-16384, -16384, -16384, -16384));
        add_row(row(16384, 16384, 16384, 16384));
        add_row(row(32767, 32767, 32767, 32767));
        add_row(row(-32768, -32768, -32768, -32768));
        add_row(row(-32768, 32767, -32768, 32767));
        add_row(row(32767, -32768, 32767, -32768));
        add_row(row(11585, 11585, 0, 0));
        add_row(row(11585, -11585, 0, 0));
        add_row(row(11585, 0, 0, -11585));
        add_row(row(8192, 8192, 8192, 8192));
        add_row(row(1, -1, 1, -1));
        add_row(row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        add_row(row(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        foreach (directed_rows[i]) send_and_drop(directed_rows[i]);
        i_valid <= 1'b0;

        // Let the pipeline drain before the random part starts.
        wait (pending_angles.size() == 0);
        @(posedge i_clk);

        // Random part: mostly unit quaternions, the rest any pattern.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - CALM_TAIL) calm = 1'b1;
            if ($urandom_range(0, 3) != 0) begin
                t = rand_unit();
            end else begin
                t = row(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            end
            send_quat(t);
            sender_gap();
        end
        i_valid <= 1'b0;

        wait (pending_angles.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_angles.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/qte_pkg.sv
hw/rtl/qte_sqrt_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/qte_front.sv
hw/rtl/quaternion_to_euler_angles_top.sv
tb/tb_quaternion_to_euler_angles_top.sv
